// File: sv/tsg_pkg.sv
package tsg_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_V2_GO,
        S_V2_WT,
        S_AD_GO,
        S_AD_WT,
        S_DIV_GO,
        S_DIV_WT,
        S_VEL_GO,
        S_VEL_WT,
        S_POS_GO,
        S_POS_WT,
        S_NEXT,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_alu_rsp;

    localparam logic [1:0] CFG_STEP_TIME    = 2'd0;
    localparam logic [1:0] CFG_ARRIVE_TOL   = 2'd1;
    localparam logic [1:0] CFG_SETTLE_SPEED = 2'd2;

    localparam logic [16:0] STEP_TIME_RST    = 17'd2185;
    localparam logic [16:0] ARRIVE_TOL_RST   = 17'd66;
    localparam logic [16:0] SETTLE_SPEED_RST = 17'd6554;

    localparam int NUM_AXES = 3;

    // Clamp a wide signed value into the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/tsg_if.sv
interface tsg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [30:0]        accel_limit;
    logic [30:0]        cruise_speed;
    logic [2:0]         snap_mask;
    logic               clear_done;

    modport source (output valid, target_x, target_y, target_z, accel_limit,
                    cruise_speed, snap_mask, clear_done, input ready);
    modport sink (input valid, target_x, target_y, target_z, accel_limit,
                  cruise_speed, snap_mask, clear_done, output ready);
endinterface

interface tsg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [2:0]         done_bits;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    acc_x, acc_y, acc_z, done_bits, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  acc_x, acc_y, acc_z, done_bits, output ready);
endinterface

interface tsg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/tsg_alu.sv
// Shared bit-serial unit: shift-add multiply, restoring divide.
module tsg_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsg_pkg::t_alu_req i_req,
    output tsg_pkg::t_alu_rsp o_rsp
);

    logic             r_busy;
    tsg_pkg::t_alu_op r_op;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_acc;
    logic [6:0]       r_cnt;

    logic [64:0] trial;
    logic        fits;
    logic        done;

    assign trial = {r_acc, r_a[63]};
    assign fits  = trial >= {1'b0, r_b};
    assign done  = r_busy && ((r_op == tsg_pkg::ALU_MUL && r_b == 64'd0) ||
                              (r_op == tsg_pkg::ALU_DIV && r_cnt == 7'd0));

    assign o_rsp.done   = done;
    assign o_rsp.result = (r_op == tsg_pkg::ALU_MUL) ? r_acc : r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= 64'd0;
            r_cnt <= 7'd64;
        end else if (r_busy && !done) begin
            case (r_op)
                tsg_pkg::ALU_MUL: begin
                    // add the shifted multiplicand for each set bit
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= {r_a[62:0], 1'b0};
                    r_b <= {1'b0, r_b[63:1]};
                end
                default: begin
                    r_acc <= fits ? 64'(trial - {1'b0, r_b}) : trial[63:0];
                    r_a   <= {r_a[62:0], fits};
                    r_cnt <= r_cnt - 7'd1;
                end
            endcase
        end
    end

endmodule

// File: sv/trapezoid_setpoint_generator_top.sv
// Trapezoidal setpoint generator for up to three axes in signed fixed point
// (FRAC_BITS fraction bits). Each input item is one tick: targets, an
// acceleration limit and a cruise speed. The block steps each axis in turn
// and returns one result item with the new positions, velocities,
// accelerations and done bits. All multiplies and the brake division run on
// one shared bit-serial unit, so a tick takes a variable number of cycles.
// An axis that is near its target only evaluates and advances. A moving
// axis evaluates, then launches and waits for v*v, 2*a*|d|, the brake divide
// when it brakes, the velocity step and the position step, then advances.
// A multiply handles one bit of its second operand per cycle up to the top
// set bit; the divide steps through all 64 bits of its dividend. One item
// is worked on at a time; the next one is taken while the previous result
// waits in the output register.
// Configuration writes are always accepted and take effect at once.
module trapezoid_setpoint_generator_top #(
    parameter int FRAC_BITS  = 16,
    parameter int AXIS_COUNT = 3
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tsg_in_if.sink    i_in,
    tsg_out_if.source o_out,
    tsg_cfg_if.sink   i_cfg
);

    localparam logic [63:0] RND_MASK = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic [1:0]  LAST_AX  = 2'(AXIS_COUNT - 1);

    tsg_pkg::t_state r_state, n_state;

    // configuration
    logic [16:0] r_step_time, r_arrive_tol, r_settle_speed;

    // axis state
    logic signed [31:0] r_pos [tsg_pkg::NUM_AXES];
    logic signed [31:0] r_vel [tsg_pkg::NUM_AXES];
    logic signed [31:0] r_acc [tsg_pkg::NUM_AXES];
    logic [2:0]         r_done;

    // held tick inputs
    logic signed [31:0] r_tgt [tsg_pkg::NUM_AXES];
    logic [30:0]        r_alim, r_cruise;

    // per-axis working registers
    logic [1:0]         r_ax;
    logic [63:0]        r_v2;
    logic [32:0]        r_ad;
    logic [31:0]        r_av;
    logic               r_dpos;
    logic signed [31:0] r_anew;

    // output register
    logic               r_ovalid;
    logic signed [31:0] r_opos [tsg_pkg::NUM_AXES];
    logic signed [31:0] r_ovel [tsg_pkg::NUM_AXES];
    logic signed [31:0] r_oacc [tsg_pkg::NUM_AXES];
    logic [2:0]         r_odone;

    tsg_pkg::t_alu_req alu_req;
    tsg_pkg::t_alu_rsp alu_rsp;

    tsg_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    logic               in_fire;
    logic               out_load;
    logic signed [31:0] cur_pos, cur_vel, cur_tgt;
    logic signed [32:0] delta;
    logic [32:0]        abs_d;
    logic [31:0]        abs_v;
    logic               far;
    logic [30:0]        a_eff;
    logic               brake;
    logic [63:0]        q;
    logic signed [31:0] a_brake;
    logic signed [31:0] a_plain;
    logic [31:0]        abs_anew;
    logic               step_neg;
    logic [63:0]        step_mag;
    logic signed [63:0] step_inc;
    logic signed [31:0] vel_new;
    logic signed [31:0] pos_new;
    logic [31:0]        abs_vnew;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_load = (r_state == tsg_pkg::S_DONE) && (!r_ovalid || o_out.ready);

    assign cur_pos = r_pos[r_ax];
    assign cur_vel = r_vel[r_ax];
    assign cur_tgt = r_tgt[r_ax];
    assign delta   = {cur_tgt[31], cur_tgt} - {cur_pos[31], cur_pos};
    assign abs_d   = delta[32] ? 33'(-delta) : 33'(delta);
    assign abs_v   = cur_vel[31] ? 32'(-cur_vel) : 32'(cur_vel);
    assign far     = abs_d >= {16'd0, r_arrive_tol};
    assign a_eff   = (r_alim == 31'd0) ? 31'd1 : r_alim;

    // brake once v*v >= 2*a*|d|
    assign brake   = r_v2 >= alu_rsp.result;
    assign a_plain = r_dpos ? $signed({1'b0, a_eff}) : -$signed({1'b0, a_eff});

    // brake acceleration from the quotient, clamped to 32 bits
    assign q = alu_rsp.result;
    always_comb begin
        if (r_dpos) begin
            a_brake = (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
        end else begin
            a_brake = (q >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        end
    end

    assign abs_anew = r_anew[31] ? 32'(-r_anew) : 32'(r_anew);
    assign abs_vnew = r_vel[r_ax][31] ? 32'(-r_vel[r_ax]) : 32'(r_vel[r_ax]);

    // floor shift of a signed product held as sign and magnitude
    assign step_neg = (r_state == tsg_pkg::S_VEL_WT) ? r_anew[31] : r_vel[r_ax][31];
    assign step_mag = step_neg ? ((alu_rsp.result + RND_MASK) >> FRAC_BITS)
                               : (alu_rsp.result >> FRAC_BITS);
    assign step_inc = step_neg ? -$signed(step_mag) : $signed(step_mag);
    assign vel_new  = tsg_pkg::sat32(64'(cur_vel) + step_inc);
    assign pos_new  = tsg_pkg::sat32(64'(cur_pos) + step_inc);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsg_pkg::S_IDLE:   if (in_fire) n_state = tsg_pkg::S_EVAL;
            tsg_pkg::S_EVAL:   n_state = far ? tsg_pkg::S_V2_GO : tsg_pkg::S_NEXT;
            tsg_pkg::S_V2_GO:  n_state = tsg_pkg::S_V2_WT;
            tsg_pkg::S_V2_WT:  if (alu_rsp.done) n_state = tsg_pkg::S_AD_GO;
            tsg_pkg::S_AD_GO:  n_state = tsg_pkg::S_AD_WT;
            tsg_pkg::S_AD_WT: begin
                if (alu_rsp.done) begin
                    n_state = (brake && r_ad != 33'd0) ? tsg_pkg::S_DIV_GO
                                                       : tsg_pkg::S_VEL_GO;
                end
            end
            tsg_pkg::S_DIV_GO: n_state = tsg_pkg::S_DIV_WT;
            tsg_pkg::S_DIV_WT: if (alu_rsp.done) n_state = tsg_pkg::S_VEL_GO;
            tsg_pkg::S_VEL_GO: n_state = tsg_pkg::S_VEL_WT;
            tsg_pkg::S_VEL_WT: if (alu_rsp.done) n_state = tsg_pkg::S_POS_GO;
            tsg_pkg::S_POS_GO: n_state = tsg_pkg::S_POS_WT;
            tsg_pkg::S_POS_WT: if (alu_rsp.done) n_state = tsg_pkg::S_NEXT;
            tsg_pkg::S_NEXT: begin
                n_state = (r_ax == LAST_AX) ? tsg_pkg::S_DONE : tsg_pkg::S_EVAL;
            end
            tsg_pkg::S_DONE:   if (out_load) n_state = tsg_pkg::S_IDLE;
            default:           n_state = tsg_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: unit requests and input ready
    always_comb begin
        alu_req       = '0;
        alu_req.op    = tsg_pkg::ALU_MUL;
        i_in.ready    = 1'b0;
        unique case (r_state)
            tsg_pkg::S_IDLE: i_in.ready = 1'b1;
            tsg_pkg::S_V2_GO: begin
                alu_req.start = 1'b1;
                alu_req.a     = 64'(r_av);
                alu_req.b     = 64'(r_av);
            end
            tsg_pkg::S_AD_GO: begin
                alu_req.start = 1'b1;
                alu_req.a     = 64'(r_ad);
                alu_req.b     = 64'({a_eff, 1'b0});
            end
            tsg_pkg::S_DIV_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = tsg_pkg::ALU_DIV;
                alu_req.a     = r_v2;
                alu_req.b     = 64'({r_ad, 1'b0});
            end
            tsg_pkg::S_VEL_GO: begin
                alu_req.start = 1'b1;
                alu_req.a     = 64'(abs_anew);
                alu_req.b     = 64'(r_step_time);
            end
            tsg_pkg::S_POS_GO: begin
                alu_req.start = 1'b1;
                alu_req.a     = 64'(abs_vnew);
                alu_req.b     = 64'(r_step_time);
            end
            default: begin
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time    <= tsg_pkg::STEP_TIME_RST;
            r_arrive_tol   <= tsg_pkg::ARRIVE_TOL_RST;
            r_settle_speed <= tsg_pkg::SETTLE_SPEED_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tsg_pkg::CFG_STEP_TIME:    r_step_time    <= i_cfg.data;
                tsg_pkg::CFG_ARRIVE_TOL:   r_arrive_tol   <= i_cfg.data;
                tsg_pkg::CFG_SETTLE_SPEED: r_settle_speed <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // axis state: clear and snap at accept, then step one axis at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tsg_pkg::NUM_AXES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
            end
            r_done <= '0;
            r_ax   <= '0;
        end else begin
            unique case (r_state)
                tsg_pkg::S_IDLE: begin
                    if (in_fire) begin
                        r_ax <= '0;
                        if (i_in.clear_done) begin
                            r_done <= '0;
                        end
                        if (AXIS_COUNT > 0 && i_in.snap_mask[0]) r_pos[0] <= i_in.target_x;
                        if (AXIS_COUNT > 1 && i_in.snap_mask[1]) r_pos[1] <= i_in.target_y;
                        if (AXIS_COUNT > 2 && i_in.snap_mask[2]) r_pos[2] <= i_in.target_z;
                    end
                end
                tsg_pkg::S_EVAL: begin
                    if (far) begin
                        r_done[r_ax] <= 1'b0;
                    end else if (abs_v < {15'd0, r_settle_speed}) begin
                        // arrived and slow: snap onto the target and finish
                        r_pos[r_ax]  <= cur_tgt;
                        r_vel[r_ax]  <= '0;
                        r_acc[r_ax]  <= '0;
                        r_done[r_ax] <= 1'b1;
                    end
                end
                tsg_pkg::S_VEL_WT: begin
                    if (alu_rsp.done) begin
                        r_acc[r_ax] <= r_anew;
                        r_vel[r_ax] <= vel_new;
                    end
                end
                tsg_pkg::S_POS_WT: begin
                    if (alu_rsp.done) begin
                        r_pos[r_ax] <= pos_new;
                    end
                end
                tsg_pkg::S_NEXT: r_ax <= r_ax + 2'd1;
                default: begin
                end
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tgt[0] <= i_in.target_x;
            r_tgt[1] <= i_in.target_y;
            r_tgt[2] <= i_in.target_z;
            r_alim   <= i_in.accel_limit;
            r_cruise <= i_in.cruise_speed;
        end
        if (r_state == tsg_pkg::S_EVAL) begin
            r_ad   <= abs_d;
            r_av   <= abs_v;
            r_dpos <= !delta[32] && (delta != 33'sd0);
        end
        if (r_state == tsg_pkg::S_V2_WT && alu_rsp.done) begin
            r_v2 <= alu_rsp.result;
        end
        if (r_state == tsg_pkg::S_AD_WT && alu_rsp.done) begin
            if (brake) begin
                r_anew <= '0;
            end else if (r_av > {1'b0, r_cruise}) begin
                r_anew <= '0;
            end else begin
                r_anew <= a_plain;
            end
        end
        if (r_state == tsg_pkg::S_DIV_WT && alu_rsp.done) begin
            r_anew <= a_brake;
        end
    end

    // output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < tsg_pkg::NUM_AXES; i++) begin
                r_opos[i] <= r_pos[i];
                r_ovel[i] <= r_vel[i];
                r_oacc[i] <= r_acc[i];
            end
            r_odone <= r_done;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.pos_x     = r_opos[0];
    assign o_out.pos_y     = r_opos[1];
    assign o_out.pos_z     = r_opos[2];
    assign o_out.vel_x     = r_ovel[0];
    assign o_out.vel_y     = r_ovel[1];
    assign o_out.vel_z     = r_ovel[2];
    assign o_out.acc_x     = r_oacc[0];
    assign o_out.acc_y     = r_oacc[1];
    assign o_out.acc_z     = r_oacc[2];
    assign o_out.done_bits = r_odone;

endmodule

// File: sv/tsg_checker.sv
module tsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_pos_x,
    input logic [2:0]  i_out_done
);

    logic in_fire;
    assign in_fire = i_in_valid && i_in_ready;

    // one tick at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in_ready)
        else $error("input taken while a tick is in progress");

    // a result never appears in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pos_x) && $stable(i_out_done))
        else $error("stalled result changed");

endmodule

bind trapezoid_setpoint_generator_top tsg_checker u_tsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pos_x (o_out.pos_x),
    .i_out_done  (o_out.done_bits)
);

// File: sim/tsg_tb_if.sv
`timescale 1ns / 1ps

// Thin wrapper so the testbench has its own file after the package; the
// channel interfaces themselves come from the RTL.
package tsg_tb_pkg;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] acc [3];
        logic [2:0]         done;
    } t_setpoint;

    typedef struct {
        logic signed [31:0] tgt [3];
        logic [30:0]        accel_limit;
        logic [30:0]        cruise_speed;
        logic [2:0]         snap_mask;
        logic               clear_done;
    } t_tick;
endpackage

// File: sim/trapezoid_setpoint_generator_top_test.sv
`timescale 1ns / 1ps

module trapezoid_setpoint_generator_top_test;

    logic i_clk;
    logic i_rst_n;

    tsg_in_if  in_ch ();
    tsg_out_if out_ch ();
    tsg_cfg_if cfg_ch ();

    trapezoid_setpoint_generator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Free-running clock, 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: the axis setpoints and the three registers.
    logic signed [31:0] sp_pos [3];
    logic signed [31:0] sp_vel [3];
    logic signed [31:0] sp_acc [3];
    logic [2:0]         sp_done;
    logic [16:0]        reg_step_time;
    logic [16:0]        reg_arrive_tol;
    logic [16:0]        reg_settle_speed;

    tsg_tb_pkg::t_setpoint setpoint_queue [$];
    int        mismatch_count;
    longint    cycle_count;
    int        hold_off_cycles;  // long receiver hold-off when non-zero
    bit        rx_stall_on;      // enable the receiver stall pattern
    int        burst_left;       // sender burst budget

    // Clamp a signed value into 32 bits.
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -128'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // Floor of x / 2^16.
    function automatic logic signed [127:0] floor_q16(input logic signed [127:0] x);
        return x >>> 16;
    endfunction

    // Advance one axis by one tick; mirrors the trapezoid rule.
    task automatic advance_axis(input int ax, input logic signed [31:0] tgt,
                                input logic [30:0] alim, input logic [30:0] cruise);
        logic signed [127:0] d, ad, av, v2, a, q, acc, vel, pos;
        d   = 128'(tgt) - 128'(sp_pos[ax]);
        ad  = d < 0 ? -d : d;
        av  = sp_vel[ax] < 0 ? -128'(sp_vel[ax]) : 128'(sp_vel[ax]);
        if (ad >= 128'(reg_arrive_tol)) begin
            v2 = av * av;
            a  = (alim == 0) ? 128'sd1 : 128'(alim);
            sp_done[ax] = 1'b0;
            if (v2 / (2 * a) >= ad) begin
                if (ad == 0) begin
                    acc = 0;
                end else begin
                    q   = v2 / (2 * ad);
                    acc = d > 0 ? -q : q;
                end
            end else if (av > 128'(cruise)) begin
                acc = 0;
            end else begin
                acc = d > 0 ? a : -a;
            end
            sp_acc[ax] = clamp32(acc);
            vel = 128'(sp_vel[ax]) + floor_q16(128'(sp_acc[ax]) * 128'(reg_step_time));
            sp_vel[ax] = clamp32(vel);
            pos = 128'(sp_pos[ax]) + floor_q16(128'(sp_vel[ax]) * 128'(reg_step_time));
            sp_pos[ax] = clamp32(pos);
        end else if (av < 128'(reg_settle_speed)) begin
            sp_pos[ax]  = tgt;
            sp_vel[ax]  = 0;
            sp_acc[ax]  = 0;
            sp_done[ax] = 1'b1;
        end
    endtask

    // Work out the expected setpoint for one accepted tick and queue it.
    task automatic predict_setpoint(input tsg_tb_pkg::t_tick t);
        tsg_tb_pkg::t_setpoint s;
        if (t.clear_done) sp_done = '0;
        for (int i = 0; i < 3; i++) if (t.snap_mask[i]) sp_pos[i] = t.tgt[i];
        for (int i = 0; i < 3; i++) advance_axis(i, t.tgt[i], t.accel_limit, t.cruise_speed);
        s.pos = sp_pos;
        s.vel = sp_vel;
        s.acc = sp_acc;
        s.done = sp_done;
        setpoint_queue.push_back(s);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR @%0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Send one tick item, at times pausing between bursts; valid stays high within a burst.
    task automatic send_tick(input tsg_tb_pkg::t_tick t);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.target_x     <= t.tgt[0];
        in_ch.target_y     <= t.tgt[1];
        in_ch.target_z     <= t.tgt[2];
        in_ch.accel_limit  <= t.accel_limit;
        in_ch.cruise_speed <= t.cruise_speed;
        in_ch.snap_mask    <= t.snap_mask;
        in_ch.clear_done   <= t.clear_done;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_setpoint(t);
    endtask

    // Drop valid, wait until every expected setpoint has come back, then settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (setpoint_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_register(input logic [1:0] idx, input logic [16:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            tsg_pkg::CFG_STEP_TIME:    reg_step_time    = val;
            tsg_pkg::CFG_ARRIVE_TOL:   reg_arrive_tol   = val;
            tsg_pkg::CFG_SETTLE_SPEED: reg_settle_speed = val;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_position(input int span);
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    // Random tick; mostly a steady target so the profile runs to arrival.
    function automatic tsg_tb_pkg::t_tick rand_tick(input tsg_tb_pkg::t_tick prev);
        tsg_tb_pkg::t_tick t;
        t = prev;
        if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < 3; i++) t.tgt[i] = rand_position(32'h0008_0000);
            t.accel_limit  = ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                             31'($urandom_range(0, 32'h0010_0000));
            t.cruise_speed = ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                             31'($urandom_range(0, 32'h0020_0000));
        end
        t.snap_mask  = ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'b000;
        t.clear_done = ($urandom_range(0, 15) == 0);
        return t;
    endfunction

    // Directed: field extremes, snap and clear flags, zero limit, zero step.
    task automatic test_directed();
        tsg_tb_pkg::t_tick t;
        t.tgt = '{32'sh0001_0000, -32'sh0002_0000, 32'sh0000_0000};
        t.accel_limit = 31'h0001_0000; t.cruise_speed = 31'h0000_8000;
        t.snap_mask = 3'b000; t.clear_done = 1'b0;
        repeat (4) send_tick(t);
        t.accel_limit = 31'h0;            // zero limit acts as one LSB
        send_tick(t);
        t.accel_limit = 31'h7FFF_FFFF; t.cruise_speed = 31'h7FFF_FFFF;
        t.tgt = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        repeat (3) send_tick(t);          // saturate towards extremes
        t.cruise_speed = 31'h0;           // above cruise: hold speed
        send_tick(t);
        t.tgt = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0};
        send_tick(t);                     // reverse: brake
        t.snap_mask = 3'b111;             // snap all axes onto target
        send_tick(t);
        t.snap_mask = 3'b101; t.clear_done = 1'b1;
        send_tick(t);
        t.snap_mask = 3'b010; t.clear_done = 1'b0;
        send_tick(t);
        drain_results();
        write_register(tsg_pkg::CFG_ARRIVE_TOL, 17'd0);   // zero distance while far
        t.snap_mask = 3'b111;
        send_tick(t);
        t.snap_mask = 3'b000;
        send_tick(t);
        drain_results();
        write_register(tsg_pkg::CFG_STEP_TIME, 17'd0);    // nothing moves
        t.tgt = '{32'sh0010_0000, 32'sh0, -32'sh0010_0000};
        t.accel_limit = 31'h0001_0000; t.cruise_speed = 31'h0002_0000;
        repeat (2) send_tick(t);
        drain_results();
        write_register(tsg_pkg::CFG_STEP_TIME, 17'h1_0000);
        write_register(tsg_pkg::CFG_ARRIVE_TOL, 17'h1_0000);
        write_register(tsg_pkg::CFG_SETTLE_SPEED, 17'h1_0000);
        repeat (3) send_tick(t);
        drain_results();
        write_register(tsg_pkg::CFG_SETTLE_SPEED, 17'd0);
        repeat (2) send_tick(t);
        drain_results();
    endtask

    // Random profiles under one register setting.
    task automatic test_random_phase(input logic [16:0] st, input logic [16:0] tol,
                                     input logic [16:0] settle, input int count);
        tsg_tb_pkg::t_tick t;
        write_register(tsg_pkg::CFG_STEP_TIME, st);
        write_register(tsg_pkg::CFG_ARRIVE_TOL, tol);
        write_register(tsg_pkg::CFG_SETTLE_SPEED, settle);
        t = rand_tick('{tgt: '{0, 0, 0}, accel_limit: 31'h1_0000,
                        cruise_speed: 31'h2_0000, snap_mask: 0, clear_done: 0});
        for (int i = 0; i < 3; i++) t.tgt[i] = rand_position(32'h0004_0000);
        repeat (count) begin
            t = rand_tick(t);
            send_tick(t);
        end
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering ticks.
    task automatic test_back_pressure();
        tsg_tb_pkg::t_tick t;
        t.tgt = '{32'sh0003_0000, 32'sh0005_0000, -32'sh0004_0000};
        t.accel_limit = 31'h0002_0000; t.cruise_speed = 31'h0001_0000;
        t.snap_mask = 3'b000; t.clear_done = 1'b0;
        hold_off_cycles = 3000;
        burst_left = 1000;
        repeat (8) send_tick(t);
        burst_left = 0;
        drain_results();   // sender pauses until everything has come back
    endtask

    // Receiver: own stall pattern, plus the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready    <= 1'b0;
        end else if (rx_stall_on) begin
            out_ch.ready <= ((cycle_count % 97) < 60) ? ($urandom_range(0, 3) != 0) : 1'b1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Check every accepted setpoint against the oldest expectation.
    always @(posedge i_clk) begin
        tsg_tb_pkg::t_setpoint w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (setpoint_queue.size() == 0) begin
                report_mismatch("unexpected setpoint", 0, 0);
            end else begin
                w = setpoint_queue.pop_front();
                if (out_ch.pos_x !== w.pos[0]) report_mismatch("pos_x", out_ch.pos_x, w.pos[0]);
                if (out_ch.pos_y !== w.pos[1]) report_mismatch("pos_y", out_ch.pos_y, w.pos[1]);
                if (out_ch.pos_z !== w.pos[2]) report_mismatch("pos_z", out_ch.pos_z, w.pos[2]);
                if (out_ch.vel_x !== w.vel[0]) report_mismatch("vel_x", out_ch.vel_x, w.vel[0]);
                if (out_ch.vel_y !== w.vel[1]) report_mismatch("vel_y", out_ch.vel_y, w.vel[1]);
                if (out_ch.vel_z !== w.vel[2]) report_mismatch("vel_z", out_ch.vel_z, w.vel[2]);
                if (out_ch.acc_x !== w.acc[0]) report_mismatch("acc_x", out_ch.acc_x, w.acc[0]);
                if (out_ch.acc_y !== w.acc[1]) report_mismatch("acc_y", out_ch.acc_y, w.acc[1]);
                if (out_ch.acc_z !== w.acc[2]) report_mismatch("acc_z", out_ch.acc_z, w.acc[2]);
                if (out_ch.done_bits !== w.done)
                    report_mismatch("done_bits", 32'(out_ch.done_bits), 32'(w.done));
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000) begin
            $display("trapezoid_setpoint_generator_top: mismatch");
            $finish;
        end
    end

    initial begin
        cycle_count      = 0;
        mismatch_count   = 0;
        hold_off_cycles  = 0;
        rx_stall_on      = 1'b0;
        burst_left       = 0;
        sp_pos = '{0, 0, 0}; sp_vel = '{0, 0, 0}; sp_acc = '{0, 0, 0};
        sp_done          = '0;
        reg_step_time    = tsg_pkg::STEP_TIME_RST;
        reg_arrive_tol   = tsg_pkg::ARRIVE_TOL_RST;
        reg_settle_speed = tsg_pkg::SETTLE_SPEED_RST;
        i_rst_n          = 1'b0;
        in_ch.valid = 1'b0; in_ch.target_x = '0; in_ch.target_y = '0;
        in_ch.target_z = '0; in_ch.accel_limit = '0; in_ch.cruise_speed = '0;
        in_ch.snap_mask = '0; in_ch.clear_done = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        rx_stall_on = 1'b1;
        test_back_pressure();
        test_random_phase(tsg_pkg::STEP_TIME_RST, tsg_pkg::ARRIVE_TOL_RST,
                          tsg_pkg::SETTLE_SPEED_RST, 250);
        test_random_phase(17'h1_0000, 17'h1_0000, 17'h1_0000, 150);
        test_random_phase(17'd1, 17'd0, 17'd0, 100);
        test_random_phase(17'h0_4000, 17'h0_0100, 17'h0_8000, 200);
        test_random_phase(17'($urandom), 17'($urandom), 17'($urandom), 120);
        drain_results();

        if (mismatch_count == 0) begin
            $display("trapezoid_setpoint_generator_top: match");
        end else begin
            $display("trapezoid_setpoint_generator_top: mismatch");
        end
        $finish;
    end

endmodule
